@@ design/ddo_pkg.sv @@
package ddo_pkg;

  // widths of the stream words and of the cfg port
  localparam int unsigned InW       = 32;
  localparam int unsigned OutW      = 112;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 16;

  // cordic step count: default and upper bound of the atan table
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned CordicStepsMax = 24;
  localparam int unsigned IterW          = $clog2(CordicStepsMax);

  // fixed point constants
  localparam logic signed [31:0] KInit       = 32'sd652032874;  // cordic gain, q.30
  localparam logic        [31:0] RadToUnits  = 32'd42722830;    // 2^27 / pi
  localparam logic        [15:0] TurnGainRst   = 16'd9830;
  localparam logic        [15:0] TravelGainRst = 16'd1966;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TURN_GAIN   = 4'd0,
    CFG_TRAVEL_GAIN = 4'd1
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HMUL1,
    ST_HMUL2,
    ST_HUPD,
    ST_CINIT,
    ST_CITER,
    ST_XMUL,
    ST_YMUL,
    ST_FINAL
  } state_e;

  // commands from sequencer to datapath
  typedef struct packed {
    logic load_in;
    logic hmul1;
    logic hmul2;
    logic hupd;
    logic cinit;
    logic citer;
    logic xmul;
    logic ymul;
    logic final_upd;
  } ddo_cmd_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic cordic_last;
  } ddo_status_t;

  // arctangent of 2^-i as a 32 bit binary angle
  function automatic logic signed [31:0] ddo_atan(input logic [IterW-1:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:  val = 32'sd536870912;
      5'd1:  val = 32'sd316933406;
      5'd2:  val = 32'sd167458907;
      5'd3:  val = 32'sd85004756;
      5'd4:  val = 32'sd42667331;
      5'd5:  val = 32'sd21354465;
      5'd6:  val = 32'sd10679838;
      5'd7:  val = 32'sd5340245;
      5'd8:  val = 32'sd2670163;
      5'd9:  val = 32'sd1335087;
      5'd10: val = 32'sd667544;
      5'd11: val = 32'sd333772;
      5'd12: val = 32'sd166886;
      5'd13: val = 32'sd83443;
      5'd14: val = 32'sd41722;
      5'd15: val = 32'sd20861;
      5'd16: val = 32'sd10430;
      5'd17: val = 32'sd5215;
      5'd18: val = 32'sd2608;
      5'd19: val = 32'sd1304;
      5'd20: val = 32'sd652;
      5'd21: val = 32'sd326;
      5'd22: val = 32'sd163;
      5'd23: val = 32'sd81;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

@@ design/ddo_ctrl.sv @@
module ddo_ctrl import ddo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ddo_status_t status_i,
  output ddo_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_HMUL1;
      ST_HMUL1: state_d = ST_HMUL2;
      ST_HMUL2: state_d = ST_HUPD;
      ST_HUPD:  state_d = ST_CINIT;
      ST_CINIT: state_d = ST_CITER;
      ST_CITER: if (status_i.cordic_last) state_d = ST_XMUL;
      ST_XMUL:  state_d = ST_YMUL;
      ST_YMUL:  state_d = ST_FINAL;
      ST_FINAL: if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // command strobes
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_HMUL1: cmd_o.hmul1 = 1'b1;
      ST_HMUL2: cmd_o.hmul2 = 1'b1;
      ST_HUPD:  cmd_o.hupd  = 1'b1;
      ST_CINIT: cmd_o.cinit = 1'b1;
      ST_CITER: cmd_o.citer = 1'b1;
      ST_XMUL:  cmd_o.xmul  = 1'b1;
      ST_YMUL:  cmd_o.ymul  = 1'b1;
      ST_FINAL: cmd_o.final_upd = out_free;
      default: cmd_o = '0;
    endcase
  end

  // output word valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.final_upd) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/ddo_datapath.sv @@
module ddo_datapath import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ddo_cmd_t             cmd_i,
  output ddo_status_t          status_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic [InW-1:0]       in_data_i,
  output logic [OutW-1:0]      out_data_o
);

  // saturating add of a signed magnitude to a 32 bit accumulator
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic [21:0] mag,
                                                 input logic neg);
    logic signed [32:0] delta;
    logic signed [32:0] total;
    logic signed [31:0] res;
    delta = neg ? -$signed({11'b0, mag}) : $signed({11'b0, mag});
    total = {acc[31], acc} + delta;
    if (total[32] != total[31]) begin
      res = total[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      res = total[31:0];
    end
    return res;
  endfunction

  logic [15:0]        turn_gain_q, travel_gain_q;
  logic [23:0]        heading_q, heading_d;
  logic signed [31:0] x_acc_q, x_acc_d, y_acc_q, y_acc_d;
  logic [31:0]        dist_q, dist_d;

  logic signed [15:0] left_q, right_q;
  logic [63:0]        prod_q;
  logic [31:0]        s_mag_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic [IterW-1:0]   iter_q;
  logic               dx_neg_q, dy_neg_q;

  logic signed [31:0] pos_x_q, pos_y_q;
  logic [15:0]        head_out_q;
  logic [31:0]        dist_out_q;

  // wheel difference and sum with their magnitudes
  logic signed [16:0] diff, sum;
  logic [15:0]        diff_mag;
  logic [16:0]        sum_mag;
  logic signed [16:0] diff_neg_v, sum_neg_v;

  assign diff       = {right_q[15], right_q} - {left_q[15], left_q};
  assign sum        = {right_q[15], right_q} + {left_q[15], left_q};
  assign diff_neg_v = -diff;
  assign sum_neg_v  = -sum;
  assign diff_mag   = diff[16] ? diff_neg_v[15:0] : diff[15:0];
  assign sum_mag    = sum[16] ? sum_neg_v : sum;

  // cordic outputs after the half turn correction
  logic signed [31:0] cos_v, sin_v, cos_n, sin_n;
  logic [31:0]        cos_mag, sin_mag;

  assign cos_v   = flip_q ? -cx_q : cx_q;
  assign sin_v   = flip_q ? -cy_q : cy_q;
  assign cos_n   = -cos_v;
  assign sin_n   = -sin_v;
  assign cos_mag = cos_v[31] ? cos_n : cos_v;
  assign sin_mag = sin_v[31] ? sin_n : sin_v;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.hmul1) begin
      mul_a = {16'b0, diff_mag};
      mul_b = {16'b0, turn_gain_q};
    end else if (cmd_i.hmul2) begin
      mul_a = prod_q[31:0];
      mul_b = RadToUnits;
    end else if (cmd_i.hupd) begin
      mul_a = {15'b0, sum_mag};
      mul_b = {16'b0, travel_gain_q};
    end else if (cmd_i.xmul) begin
      mul_a = s_mag_q;
      mul_b = cos_mag;
    end else if (cmd_i.ymul) begin
      mul_a = s_mag_q;
      mul_b = sin_mag;
    end
  end

  assign mul_p = mul_a * mul_b;

  // heading step, rounded to nearest with ties away from zero
  logic [63:0] hd_round;
  assign hd_round  = prod_q + 64'h0000_0000_8000_0000;
  assign heading_d = diff[16] ? heading_q - hd_round[55:32] : heading_q + hd_round[55:32];

  // position step rounded from q.58 to q16.16
  logic [63:0] xy_round;
  assign xy_round = prod_q + 64'h0000_0200_0000_0000;
  assign x_acc_d  = sat_add(x_acc_q, xy_round[63:42], dx_neg_q);
  assign y_acc_d  = sat_add(y_acc_q, xy_round[63:42], dy_neg_q);

  // path length step and saturating total
  logic [32:0] step_round, dist_sum;
  assign step_round = {1'b0, s_mag_q} + 33'd2048;
  assign dist_sum   = {1'b0, dist_q} + {12'b0, step_round[32:12]};
  assign dist_d     = dist_sum[32] ? 32'hFFFF_FFFF : dist_sum[31:0];

  // one cordic micro-rotation
  logic signed [31:0] xs, ys, atan_v;
  assign xs     = cx_q >>> iter_q;
  assign ys     = cy_q >>> iter_q;
  assign atan_v = ddo_atan(iter_q);

  assign status_o.cordic_last = (iter_q == IterW'(CORDIC_STEPS - 1));

  // configuration and odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q   <= TurnGainRst;
      travel_gain_q <= TravelGainRst;
      heading_q     <= '0;
      x_acc_q       <= '0;
      y_acc_q       <= '0;
      dist_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TURN_GAIN:   turn_gain_q   <= cfg_data_i;
          CFG_TRAVEL_GAIN: travel_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.hupd) heading_q <= heading_d;
      if (cmd_i.ymul) x_acc_q   <= x_acc_d;
      if (cmd_i.final_upd) begin
        y_acc_q <= y_acc_d;
        dist_q  <= dist_d;
      end
    end
  end

  // working registers and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      left_q  <= in_data_i[15:0];
      right_q <= in_data_i[31:16];
    end
    if (cmd_i.hmul1 || cmd_i.hmul2 || cmd_i.xmul || cmd_i.ymul) begin
      prod_q <= mul_p;
    end
    if (cmd_i.hupd) s_mag_q <= mul_p[31:0];
    if (cmd_i.cinit) begin
      // quadrants two and three are turned by a half turn first
      flip_q <= heading_q[23] ^ heading_q[22];
      cz_q   <= {heading_q[22], heading_q[22:0], 8'b0};
      cx_q   <= KInit;
      cy_q   <= '0;
      iter_q <= '0;
    end else if (cmd_i.citer) begin
      if (!cz_q[31]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_v;
      end
      iter_q <= iter_q + 1'b1;
    end
    if (cmd_i.xmul) dx_neg_q <= sum[16] ^ cos_v[31];
    if (cmd_i.ymul) dy_neg_q <= sum[16] ^ sin_v[31];
    if (cmd_i.final_upd) begin
      pos_x_q    <= x_acc_q;
      pos_y_q    <= y_acc_d;
      head_out_q <= heading_q[23:8];
      dist_out_q <= dist_d;
    end
  end

  assign out_data_o = {dist_out_q, head_out_q, pos_y_q, pos_x_q};

endmodule

@@ design/differential_drive_odometry_unit.sv @@
// Dead-reckoning odometry for a two-wheel robot. Each input word carries the
// left and right wheel angle changes of one sample period; the unit turns
// the heading by turn_gain * (right - left), takes cosine and sine of the
// new heading with an iterative CORDIC, advances x and y by
// travel_gain * (left + right) along it, and adds the step length to the
// path distance, returning one output word per input word. A new input word
// is taken only once the unit is through with the last one: the CORDIC does
// one micro-rotation per cycle, a single 32x32 multiplier serves the two
// heading products, the travel product and the x and y components, and
// further steps load the CORDIC and complete the totals. A finished word waits
// in the output register while the next input word is taken in; a word that
// is still waiting there holds the unit in its last step. Gains are to be
// written through the cfg port only while the unit is idle; the unit itself
// does not enforce this.
module differential_drive_odometry_unit import ddo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // left_delta_angle [15:0], right_delta_angle [31:16]
  input  logic [InW-1:0]      s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x [31:0], pos_y [63:32], heading [79:64], path_distance [111:80]
  output logic [OutW-1:0]     m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ddo_cmd_t    cmd;
  ddo_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  ddo_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ design/ddo_checker.sv @@
module ddo_checker import ddo_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic            cfg_ready_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // an accepted input word keeps the unit busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // a new result never appears right after an input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early");

  // the gain registers always take writes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("cfg port not ready");

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ddo_pkg::*;

  localparam int unsigned CordicSteps = CordicStepsDef;
  localparam int          SettleCycles = 40;    // beyond the latency of one word
  localparam int          StallCycles  = 400;
  localparam int          WatchdogLimit = 4000;
  localparam int          ChunkItems   = 275;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 4'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic        [31:0] path_distance;
  } pose_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [InW-1:0]      s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutW-1:0]     m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  differential_drive_odometry_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // gains as the unit should hold them
  logic [15:0] turn_gain_r   = TurnGainRst;
  logic [15:0] travel_gain_r = TravelGainRst;

  // odometry state of the predictor
  logic [23:0] head_acc = '0;
  longint      x_pos    = 0;
  longint      y_pos    = 0;
  longint      dist_acc = 0;

  longint atan_q32 [CordicStepsMax];

  logic [InW-1:0] pending_wheels_q [$];
  pose_t          predicted_pose_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  bit long_stall_req = 1'b0;

  // arctangent of 2^-i as a 32 bit binary angle
  initial begin
    real t;
    t = 1.0;
    for (int i = 0; i < CordicStepsMax; i++) begin
      atan_q32[i] = $rtoi($atan(t) * 4294967296.0 / (2.0 * 3.14159265358979323846) + 0.5);
      t = t / 2.0;
    end
  end

  // divide by 2^sh, rounding to nearest with ties away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rotation mode cordic, cosine and sine in q.30
  function automatic void cordic_rot(input logic [31:0] ang, output longint co,
                                     output longint si);
    logic [31:0] a;
    bit          flip;
    longint      xc, yc, z, xs, ys;
    a = ang;
    flip = 1'b0;
    if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
      a = a - 32'h8000_0000;
      flip = 1'b1;
    end
    z = $signed(a);
    xc = KInit;
    yc = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = xc >>> i;
      ys = yc >>> i;
      if (z >= 0) begin
        xc = xc - ys;
        yc = yc + xs;
        z = z - atan_q32[i];
      end else begin
        xc = xc + ys;
        yc = yc - xs;
        z = z + atan_q32[i];
      end
    end
    co = flip ? -xc : xc;
    si = flip ? -yc : yc;
  endfunction

  // advance the pose by one pair of wheel steps
  function automatic pose_t advance_pose(input logic [InW-1:0] wheels);
    longint l, r, p, d, co, si, s, step;
    pose_t  res;
    l = $signed(wheels[15:0]);
    r = $signed(wheels[31:16]);
    p = longint'(turn_gain_r) * (r - l);
    d = round_away(p * longint'(RadToUnits), 32);
    head_acc = head_acc + d[23:0];
    cordic_rot({head_acc, 8'h00}, co, si);
    s = longint'(travel_gain_r) * (l + r);
    x_pos = clamp32(x_pos + round_away(s * co, 42));
    y_pos = clamp32(y_pos + round_away(s * si, 42));
    step = round_away((s < 0) ? -s : s, 12);
    dist_acc = dist_acc + step;
    if (dist_acc > 64'sd4294967295) dist_acc = 64'sd4294967295;
    res.pos_x = x_pos[31:0];
    res.pos_y = y_pos[31:0];
    res.heading = head_acc[23:8];
    res.path_distance = dist_acc[31:0];
    return res;
  endfunction

  // wheel driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_pose_q.push_back(advance_pose(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_wheels_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata  <= pending_wheels_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // pose monitor and receiver backpressure
  int stall_left = 0;
  bit stall_ack  = 1'b0;

  function automatic bit stall_req_pending();
    return long_stall_req != stall_ack;
  endfunction

  always @(posedge clk_i) begin
    pose_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        got.pos_x = m_axis_tdata[31:0];
        got.pos_y = m_axis_tdata[63:32];
        got.heading = m_axis_tdata[79:64];
        got.path_distance = m_axis_tdata[111:80];
        if (predicted_pose_q.size() == 0) begin
          $display("%0t: pose word with none expected, got %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = predicted_pose_q.pop_front();
          check_field("pos_x", want.pos_x, got.pos_x);
          check_field("pos_y", want.pos_y, got.pos_y);
          check_field("heading", want.heading, got.heading);
          check_field("path_distance", want.path_distance, got.path_distance);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_req_pending()) begin
        stall_ack = long_stall_req;
        stall_left = StallCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on handshake activity
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_wheels(input int l, input int r);
    pending_wheels_q.push_back({r[15:0], l[15:0]});
  endfunction

  function automatic int wheel_extreme();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return -1;
      2:       return 0;
      3:       return 1;
      default: return 32767;
    endcase
  endfunction

  // random wheel word: full range in four of ten, else small, medium, straight, spin or extremes
  function automatic logic [31:0] random_wheels();
    int kind, l, r;
    kind = $urandom_range(9);
    case (kind)
      0, 1, 2, 3: begin
        l = $urandom;
        r = $urandom;
      end
      4, 5: begin
        l = int'($urandom_range(128)) - 64;
        r = int'($urandom_range(128)) - 64;
      end
      6: begin
        l = $urandom;
        r = l;
      end
      7: begin
        l = int'($urandom_range(65535)) - 32768;
        r = -l;
      end
      8: begin
        l = wheel_extreme();
        r = wheel_extreme();
      end
      default: begin
        l = int'($urandom_range(4096)) - 2048;
        r = int'($urandom_range(4096)) - 2048;
      end
    endcase
    return {r[15:0], l[15:0]};
  endfunction

  // register write through the cfg channel
  task automatic write_gain(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TURN_GAIN) turn_gain_r = val;
    else if (idx == CFG_TRAVEL_GAIN) travel_gain_r = val;
  endtask

  task automatic set_gains(input logic [15:0] turn, input logic [15:0] travel);
    write_gain(CFG_TURN_GAIN, turn);
    write_gain(CFG_TRAVEL_GAIN, travel);
  endtask

  // wait until every queued word is through and every pose has come back
  task automatic wait_drained();
    while (pending_wheels_q.size() != 0 || s_axis_tvalid || predicted_pose_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_chunk(input int count);
    repeat (count) pending_wheels_q.push_back(random_wheels());
    wait_drained();
  endtask

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset gains, extremes of both wheels
    queue_wheels(0, 0);
    queue_wheels(32767, 32767);
    queue_wheels(-32768, -32768);
    queue_wheels(-32768, 32767);
    queue_wheels(32767, -32768);
    queue_wheels(1, -1);
    queue_wheels(-1, 1);
    wait_drained();

    // full gains, heading wraps
    set_gains(16'hFFFF, 16'hFFFF);
    queue_wheels(-32768, 32767);
    queue_wheels(32767, -32768);
    queue_wheels(32767, 32767);
    queue_wheels(-32768, -32768);
    queue_wheels(0, 32767);
    queue_wheels(-32768, 0);
    wait_drained();

    // write to an unmapped index is dropped, then zero gains
    write_gain(CFG_UNMAPPED, 16'h1234);
    set_gains(16'h0000, 16'h0000);
    queue_wheels(32767, -32768);
    queue_wheels(12345, -321);
    wait_drained();

    set_gains(16'h0001, 16'h0001);
    queue_wheels(1, 0);
    queue_wheels(-1, 0);
    queue_wheels(32767, 32767);
    wait_drained();

    // walk the heading through every quadrant
    set_gains(16'd16384, 16'd30000);
    repeat (6) queue_wheels(-8000, 8000);
    wait_drained();

    // random part, sender idle 18 and receiver idle 72
    send_idle_pct = 18;
    recv_idle_pct = 72;
    set_gains(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    run_chunk(ChunkItems);
    set_gains(16'hFFFF, 16'hFFFF);
    run_chunk(ChunkItems);

    // sender idle 72 and receiver idle 18
    send_idle_pct = 72;
    recv_idle_pct = 18;
    set_gains(16'h0000, 16'($urandom_range(65535)));
    run_chunk(ChunkItems);
    set_gains(16'($urandom_range(65535)), 16'h0000);
    run_chunk(ChunkItems);

    // no idling, long receiver stall while words keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_gains(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    long_stall_req <= ~long_stall_req;
    run_chunk(ChunkItems);

    // more random gains without idling
    set_gains(16'($urandom_range(65535)), 16'($urandom_range(65535)));
    run_chunk(ChunkItems);

    if (mismatch_count == 0 && predicted_pose_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ddo_pkg.sv
design/ddo_ctrl.sv
design/ddo_datapath.sv
design/differential_drive_odometry_unit.sv
design/ddo_checker.sv
sim/testbench.sv
